/* design/ls_pkg.sv */
// Shared types and constants for the lottery scheduler.
package ls_pkg;

    localparam int MODE_W = 2;
    localparam int SLOT_W = 6;
    localparam int TVAL_W = 16;
    localparam int MASK_W = 64;
    localparam int WINS_W = 32;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd2;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;
    localparam int          RND_LSB = 16;
    localparam int          RND_W   = 15;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic tk_we;
        logic wn_we;
        logic clr;
    } t_store_ctl;

endpackage

/* design/ls_alu.sv */
// Shared add/subtract unit with borrow, used for ticket sums, modulo and the walk.
module ls_alu import ls_pkg::*; #(
    parameter int W = 24
) (
    input  t_alu_op        i_op,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [W-1:0]   o_y,
    output logic           o_borrow
);

    logic [W:0] diff;

    assign diff     = {1'b0, i_a} - {1'b0, i_b};
    assign o_borrow = diff[W];

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = diff[W-1:0];
            default: o_y = diff[W-1:0];
        endcase
    end

endmodule

/* design/ls_slot_store.sv */
// Ticket and win count tables with per-entry valid bits and registered reads.
module ls_slot_store import ls_pkg::*; #(
    parameter int NUM_SLOTS   = 64,
    parameter int TICKET_BITS = 16,
    localparam int SW         = $clog2(NUM_SLOTS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_store_ctl             i_ctl,
    input  logic [SW-1:0]          i_wr_addr,
    input  logic [TICKET_BITS-1:0] i_wr_tk,
    input  logic [WINS_W-1:0]      i_wr_wn,
    input  logic [SW-1:0]          i_rd_addr,
    output logic [TICKET_BITS-1:0] o_rd_tk,
    output logic [WINS_W-1:0]      o_rd_wn
);

    logic [TICKET_BITS-1:0] r_tk_mem [NUM_SLOTS];
    logic [WINS_W-1:0]      r_wn_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   r_tk_vld;
    logic [NUM_SLOTS-1:0]   r_wn_vld;
    logic [TICKET_BITS-1:0] r_tk_q;
    logic [WINS_W-1:0]      r_wn_q;
    logic                   r_tk_qv;
    logic                   r_wn_qv;

    always_ff @(posedge i_clk) begin
        if (i_ctl.tk_we) begin
            r_tk_mem[i_wr_addr] <= i_wr_tk;
        end
        if (i_ctl.wn_we) begin
            r_wn_mem[i_wr_addr] <= i_wr_wn;
        end
        r_tk_q  <= r_tk_mem[i_rd_addr];
        r_wn_q  <= r_wn_mem[i_rd_addr];
        r_tk_qv <= r_tk_vld[i_rd_addr];
        r_wn_qv <= r_wn_vld[i_rd_addr];
    end

    // unwritten entries read as one ticket, zero wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tk_vld <= '0;
            r_wn_vld <= '0;
        end else begin
            if (i_ctl.clr) begin
                r_tk_vld[i_wr_addr] <= 1'b0;
                r_wn_vld[i_wr_addr] <= 1'b0;
            end
            if (i_ctl.tk_we) begin
                r_tk_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.wn_we) begin
                r_wn_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_tk = r_tk_qv ? r_tk_q : TICKET_BITS'(1);
    assign o_rd_wn = r_wn_qv ? r_wn_q : '0;

endmodule

/* design/lottery_scheduler_top.sv */
// Lottery scheduler top level: command sequencer, LCG and draw datapath.
// One word is taken when start is high and busy is low; its result word appears
// on the o_ ports for exactly one cycle with o_done high, and cannot be held off.
// Allocate, set tickets and undefined modes give their result from S_EXEC through
// the output registers. A draw walks the first MIN(NUM_SLOTS,64) slots twice
// through its single read port, runs 15 restoring-division steps on the shared
// add/subtract unit and updates the LCG in S_LCGM and S_LCGA; a draw over zero
// tickets ends after the sum, in S_LCGM, before the LCG update and without a winner.
// busy stays high until the result cycle, in which the next word may be accepted.
module lottery_scheduler_top import ls_pkg::*; #(
    parameter int NUM_SLOTS   = 64,
    parameter int TICKET_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [TVAL_W-1:0]  i_ticket_value,
    input  logic [MASK_W-1:0]  i_runnable_mask,
    output logic               o_done,
    output logic               o_granted,
    output logic [SLOT_W-1:0]  o_winner_slot,
    output logic               o_error,
    output logic [WINS_W-1:0]  o_winner_wins
);

    localparam int SW   = $clog2(NUM_SLOTS);
    localparam int MS   = (NUM_SLOTS < MASK_W) ? NUM_SLOTS : MASK_W;
    localparam int SUMW = TICKET_BITS + $clog2(MS);
    localparam int AW   = SUMW + 1;
    localparam logic [SW-1:0] LAST = SW'(MS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_LCGM = 3'd3;
    localparam logic [2:0] S_LCGA = 3'd4;
    localparam logic [2:0] S_MOD  = 3'd5;
    localparam logic [2:0] S_WALK = 3'd6;
    localparam logic [2:0] S_WIN  = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [MODE_W-1:0]      r_mode, n_mode;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [TICKET_BITS-1:0] r_tval, n_tval;
    logic [MASK_W-1:0]      r_mask, n_mask;
    logic [31:0]            r_lcg, n_lcg;
    logic [31:0]            r_prod, n_prod;
    logic [RND_W-1:0]       r_rnd, n_rnd;
    logic [3:0]             r_bit, n_bit;
    logic [SUMW-1:0]        r_acc, n_acc;
    logic [SUMW-1:0]        r_rem, n_rem;
    logic [SW-1:0]          r_idx, n_idx;
    logic                   r_iss, n_iss;
    logic                   r_pend, n_pend;
    logic [SW-1:0]          r_pidx, n_pidx;
    logic [SW-1:0]          r_win, n_win;
    logic [WINS_W-1:0]      r_wins, n_wins;
    logic                   r_done, n_done;
    logic                   r_granted, n_granted;
    logic [SLOT_W-1:0]      r_wslot, n_wslot;
    logic                   r_err, n_err;
    logic [WINS_W-1:0]      r_wins_o, n_wins_o;

    t_store_ctl             st_ctl;
    logic [SW-1:0]          wr_addr;
    logic [TICKET_BITS-1:0] rd_tk;
    logic [WINS_W-1:0]      rd_wn;
    t_alu_op                alu_op;
    logic [AW-1:0]          alu_a, alu_b, alu_y;
    logic                   alu_borrow;
    logic                   in_range;
    logic                   mask_bit;
    logic [31:0]            lcg_sum;

    ls_slot_store #(
        .NUM_SLOTS   (NUM_SLOTS),
        .TICKET_BITS (TICKET_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (st_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_tk   (r_tval),
        .i_wr_wn   (r_wins),
        .i_rd_addr (r_idx),
        .o_rd_tk   (rd_tk),
        .o_rd_wn   (rd_wn)
    );

    ls_alu #(
        .W (AW)
    ) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

    assign in_range = (32'(r_slot) < NUM_SLOTS);
    assign mask_bit = r_mask[6'(r_pidx)];
    assign lcg_sum  = r_prod + LCG_ADD;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_slot    = r_slot;
        n_tval    = r_tval;
        n_mask    = r_mask;
        n_lcg     = r_lcg;
        n_prod    = r_prod;
        n_rnd     = r_rnd;
        n_bit     = r_bit;
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_idx     = r_idx;
        n_iss     = r_iss;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_win     = r_win;
        n_wins    = r_wins;
        n_done    = 1'b0;
        n_granted = r_granted;
        n_wslot   = r_wslot;
        n_err     = r_err;
        n_wins_o  = r_wins_o;
        st_ctl    = '0;
        wr_addr   = SW'(r_slot);
        alu_op    = ALU_ADD;
        alu_a     = AW'(r_acc);
        alu_b     = AW'(rd_tk);

        // table read pipeline: address now, data next cycle
        if (r_state == S_SUM || r_state == S_WALK) begin
            if (r_iss) begin
                n_pend = 1'b1;
                n_pidx = r_idx;
                if (r_idx == LAST) begin
                    n_iss = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end else begin
                n_pend = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                    n_mode  = i_mode;
                    n_slot  = i_slot;
                    n_tval  = TICKET_BITS'(i_ticket_value);
                    n_mask  = i_runnable_mask;
                end
            end
            S_EXEC: begin
                n_state   = S_IDLE;
                n_done    = 1'b1;
                n_granted = 1'b0;
                n_wslot   = '0;
                n_err     = 1'b0;
                n_wins_o  = '0;
                unique case (r_mode)
                    MODE_ALLOC: begin
                        st_ctl.clr = in_range;
                    end
                    MODE_SET: begin
                        if (r_tval == '0) begin
                            n_err = 1'b1;
                        end else begin
                            st_ctl.tk_we = in_range;
                        end
                    end
                    MODE_DRAW: begin
                        n_state = S_SUM;
                        n_done  = 1'b0;
                        n_idx   = '0;
                        n_iss   = 1'b1;
                        n_pend  = 1'b0;
                        n_acc   = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_SUM: begin
                if (r_pend) begin
                    if (mask_bit) begin
                        n_acc = alu_y[SUMW-1:0];
                    end
                    if (r_pidx == LAST) begin
                        n_state = S_LCGM;
                    end
                end
            end
            S_LCGM: begin
                if (r_acc == '0) begin
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                    n_granted = 1'b0;
                    n_wslot   = '0;
                    n_err     = 1'b0;
                    n_wins_o  = '0;
                end else begin
                    n_prod  = r_lcg * LCG_MUL;
                    n_state = S_LCGA;
                end
            end
            S_LCGA: begin
                n_lcg   = lcg_sum;
                n_rnd   = lcg_sum[RND_LSB +: RND_W];
                n_rem   = '0;
                n_bit   = 4'(RND_W - 1);
                n_state = S_MOD;
            end
            S_MOD: begin
                // restoring division, one bit of the draw per step
                alu_op = ALU_SUB;
                alu_a  = {r_rem, r_rnd[r_bit]};
                alu_b  = AW'(r_acc);
                n_rem  = alu_borrow ? alu_a[SUMW-1:0] : alu_y[SUMW-1:0];
                if (r_bit == '0) begin
                    n_state = S_WALK;
                    n_idx   = '0;
                    n_iss   = 1'b1;
                    n_pend  = 1'b0;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_WALK: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(r_rem);
                alu_b  = AW'(rd_tk);
                if (r_pend && mask_bit) begin
                    if (alu_borrow) begin
                        n_win   = r_pidx;
                        n_wins  = rd_wn + 32'd1;
                        n_state = S_WIN;
                    end else begin
                        n_rem = alu_y[SUMW-1:0];
                    end
                end
            end
            S_WIN: begin
                st_ctl.wn_we = 1'b1;
                wr_addr      = r_win;
                n_state      = S_IDLE;
                n_done       = 1'b1;
                n_granted    = 1'b1;
                n_wslot      = SLOT_W'(r_win);
                n_err        = 1'b0;
                n_wins_o     = r_wins;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lcg   <= 32'd1;
            r_iss   <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lcg   <= n_lcg;
            r_iss   <= n_iss;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_slot    <= n_slot;
        r_tval    <= n_tval;
        r_mask    <= n_mask;
        r_prod    <= n_prod;
        r_rnd     <= n_rnd;
        r_bit     <= n_bit;
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_win     <= n_win;
        r_wins    <= n_wins;
        r_granted <= n_granted;
        r_wslot   <= n_wslot;
        r_err     <= n_err;
        r_wins_o  <= n_wins_o;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_granted     = r_granted;
    assign o_winner_slot = r_wslot;
    assign o_error       = r_err;
    assign o_winner_wins = r_wins_o;

endmodule

/* dv/lottery_scheduler_top_test.sv */
// Testbench for the lottery scheduler: queued command driver, result monitor, table predictor.
`timescale 1ns / 100ps

module lottery_scheduler_top_test;
    import ls_pkg::*;

    localparam int NUM_SLOTS    = 64;
    localparam int TICKET_BITS  = 16;
    localparam int RANDOM_WORDS = 1250;
    localparam int CALM_TAIL    = 150;
    localparam int DRAIN_CYCLES = 160;
    localparam int WATCH_LIMIT  = 2000;
    localparam int SHOW_LIMIT   = 10;

    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [TVAL_W-1:0] tval;
        logic [MASK_W-1:0] runnable;
    } t_word;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic              error;
        logic [WINS_W-1:0] wins;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [MODE_W-1:0]  i_mode = '0;
    logic [SLOT_W-1:0]  i_slot = '0;
    logic [TVAL_W-1:0]  i_ticket_value = '0;
    logic [MASK_W-1:0]  i_runnable_mask = '0;
    logic               o_done;
    logic               o_granted;
    logic [SLOT_W-1:0]  o_winner_slot;
    logic               o_error;
    logic [WINS_W-1:0]  o_winner_wins;

    lottery_scheduler_top #(
        .NUM_SLOTS   (NUM_SLOTS),
        .TICKET_BITS (TICKET_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_slot          (i_slot),
        .i_ticket_value  (i_ticket_value),
        .i_runnable_mask (i_runnable_mask),
        .o_done          (o_done),
        .o_granted       (o_granted),
        .o_winner_slot   (o_winner_slot),
        .o_error         (o_error),
        .o_winner_wins   (o_winner_wins)
    );

    // scheduler shadow state
    logic [31:0]            lcg_q;
    logic [TICKET_BITS-1:0] tickets [NUM_SLOTS];
    logic [WINS_W-1:0]      win_tally [NUM_SLOTS];

    t_word    word_q [$];
    t_outcome outcome_q [$];
    t_word    cur_word;

    int gap_left = 0;
    int sent = 0;
    int quiet_cycles = 0;
    int faults = 0;
    int n_alloc = 0, n_set = 0, n_draw = 0, n_undef = 0;
    int n_granted = 0, n_rejected = 0;
    bit timed_out = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_outcome predict_outcome(t_word w);
        t_outcome o;
        logic [31:0] total;
        logic [31:0] rem;
        logic [TICKET_BITS-1:0] tv;
        bit found;
        int i;
        o = '0;
        tv = w.tval[TICKET_BITS-1:0];
        case (w.mode)
            MODE_ALLOC: begin
                if (w.slot < NUM_SLOTS) begin
                    tickets[w.slot] = TICKET_BITS'(1);
                    win_tally[w.slot] = '0;
                end
            end
            MODE_SET: begin
                if (tv == 0)
                    o.error = 1'b1;
                else if (w.slot < NUM_SLOTS)
                    tickets[w.slot] = tv;
            end
            MODE_DRAW: begin
                total = 0;
                for (i = 0; i < NUM_SLOTS && i < MASK_W; i++)
                    if (w.runnable[i])
                        total += 32'(tickets[i]);
                if (total != 0) begin
                    lcg_q = lcg_q * LCG_MUL + LCG_ADD;
                    rem = ((lcg_q >> RND_LSB) & ((32'd1 << RND_W) - 1)) % total;
                    found = 1'b0;
                    for (i = 0; i < NUM_SLOTS && i < MASK_W; i++) begin
                        if (!found && w.runnable[i]) begin
                            if (rem < 32'(tickets[i])) begin
                                win_tally[i] = win_tally[i] + 32'd1;
                                o.granted = 1'b1;
                                o.slot = i[SLOT_W-1:0];
                                o.wins = win_tally[i];
                                found = 1'b1;
                            end else begin
                                rem -= 32'(tickets[i]);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic t_word mk_word(logic [MODE_W-1:0] m, int s, int t, logic [MASK_W-1:0] r);
        t_word w;
        w.mode = m;
        w.slot = s[SLOT_W-1:0];
        w.tval = t[TVAL_W-1:0];
        w.runnable = r;
        return w;
    endfunction

    function automatic t_word pick_word();
        t_word w;
        int k;
        int sel;
        w.slot = SLOT_W'($urandom_range(0, 63));
        w.tval = TVAL_W'($urandom());
        w.runnable = {$urandom(), $urandom()};
        k = $urandom_range(0, 99);
        if (k < 3)
            w.mode = MODE_UNDEF;
        else if (k < 13)
            w.mode = MODE_ALLOC;
        else if (k < 43)
            w.mode = MODE_SET;
        else
            w.mode = MODE_DRAW;
        if (w.mode == MODE_SET) begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                w.tval = '0;
            else if (sel < 40)
                w.tval = TVAL_W'($urandom_range(1, 15));
            else if (sel < 60)
                w.tval = TVAL_W'(32'hFFFF - $urandom_range(0, 255));
        end else if (w.mode == MODE_DRAW) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: w.runnable = '0;
                1: w.runnable = '1;
                2: w.runnable = 64'd1 << $urandom_range(0, 63);
                3, 4: w.runnable = w.runnable & {$urandom(), $urandom()}
                                   & {$urandom(), $urandom()};
                5: w.runnable = w.runnable | {$urandom(), $urandom()};
                default: ;
            endcase
        end
        return w;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (!(start && busy)) begin
            if (start) begin
                outcome_q.push_back(predict_outcome(cur_word));
                sent++;
                case (cur_word.mode)
                    MODE_ALLOC: n_alloc++;
                    MODE_SET:   n_set++;
                    MODE_DRAW:  n_draw++;
                    default:    n_undef++;
                endcase
            end
            if (gap_left != 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (word_q.size() > CALM_TAIL && ((sent / 120) % 3) != 0
                         && $urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                gap_left <= $urandom_range(0, 8);
            end else if (word_q.size() != 0) begin
                cur_word = word_q.pop_front();
                start <= 1'b1;
                i_mode <= cur_word.mode;
                i_slot <= cur_word.slot;
                i_ticket_value <= cur_word.tval;
                i_runnable_mask <= cur_word.runnable;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic flag_fault(string what, t_outcome want, t_outcome got);
        faults++;
        if (faults <= SHOW_LIMIT)
            $display("%0t %s: want g=%0d slot=%0d err=%0d wins=%0d, %s",
                     $time, what, want.granted, want.slot, want.error, want.wins,
                     $sformatf("got g=%0d slot=%0d err=%0d wins=%0d",
                               got.granted, got.slot, got.error, got.wins));
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_done) begin
            got = {o_granted, o_winner_slot, o_error, o_winner_wins};
            if (o_granted === 1'b1)
                n_granted++;
            if (o_error === 1'b1)
                n_rejected++;
            if (outcome_q.size() == 0) begin
                flag_fault("stray result word", '0, got);
            end else begin
                want = outcome_q.pop_front();
                if (got !== want)
                    flag_fault("result mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        int counted;
        t_word w;
        lcg_q = 32'd1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tickets[i] = TICKET_BITS'(1);
            win_tally[i] = '0;
        end

        word_q.push_back(mk_word(MODE_DRAW, 0, 0, '1));
        word_q.push_back(mk_word(MODE_DRAW, 63, 16'hFFFF, '0));
        word_q.push_back(mk_word(MODE_UNDEF, 17, 16'h1234, 64'hDEAD_BEEF_0123_4567));
        word_q.push_back(mk_word(MODE_SET, 0, 0, '1));
        word_q.push_back(mk_word(MODE_SET, 63, 16'hFFFF, '0));
        word_q.push_back(mk_word(MODE_SET, 0, 1, '1));
        word_q.push_back(mk_word(MODE_DRAW, 0, 0, 64'h8000_0000_0000_0000));
        word_q.push_back(mk_word(MODE_DRAW, 0, 0, 64'h8000_0000_0000_0001));
        word_q.push_back(mk_word(MODE_DRAW, 0, 0, '1));
        word_q.push_back(mk_word(MODE_ALLOC, 63, 16'hFFFF, '1));
        word_q.push_back(mk_word(MODE_ALLOC, 0, 0, '0));
        word_q.push_back(mk_word(MODE_SET, 5, 0, '0));
        word_q.push_back(mk_word(MODE_DRAW, 5, 0, 64'h20));
        word_q.push_back(mk_word(MODE_SET, 31, 16'h8000, '0));
        word_q.push_back(mk_word(MODE_DRAW, 0, 0, '1));
        word_q.push_back(mk_word(MODE_DRAW, 0, 0, 64'h0000_0000_8000_0000));
        word_q.push_back(mk_word(MODE_SET, 2, 16'h7FFF, '0));
        word_q.push_back(mk_word(MODE_DRAW, 0, 0, 64'h5555_5555_5555_5555));
        word_q.push_back(mk_word(MODE_DRAW, 0, 0, 64'hAAAA_AAAA_AAAA_AAAA));
        word_q.push_back(mk_word(MODE_UNDEF, 63, 16'hFFFF, '1));
        word_q.push_back(mk_word(MODE_DRAW, 0, 0, '1));

        counted = 0;
        while (counted < RANDOM_WORDS) begin
            w = pick_word();
            word_q.push_back(w);
            if (w.mode != MODE_UNDEF)
                counted++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sampled on the falling edge to stay clear of driver updates
        while (!(word_q.size() == 0 && !start && outcome_q.size() == 0)) begin
            @(negedge i_clk);
            if (quiet_cycles >= WATCH_LIMIT) begin
                timed_out = 1'b1;
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                break;
            end
        end
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words: %0d draws (%0d granted), %0d ticket sets (%0d rejected)",
                 sent, n_draw, n_granted, n_set, n_rejected);
        $display("%0d allocations, %0d undefined-mode words, %0d faults",
                 n_alloc, n_undef, faults);
        if (!timed_out && faults == 0 && outcome_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
design/ls_pkg.sv
design/ls_alu.sv
design/ls_slot_store.sv
design/lottery_scheduler_top.sv
dv/lottery_scheduler_top_test.sv
